### sv/hpid_pkg.sv
package hpid_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int GAIN_W     = 24;
  localparam int PERIOD_W   = 16;

  localparam int ERR_W      = 25;
  localparam int INTEG_W    = 48;
  localparam int DERIV_W    = 42;
  localparam int SUM_W      = 60;
  localparam int DRIVE_W    = 32;

  // shared multiplier: signed A times unsigned B
  localparam int MUL_A_W    = 26;
  localparam int MUL_B_W    = 24;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST  = 16'd1311;
  localparam logic [PERIOD_W-1:0] INVERSE_PERIOD_RST = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_SAMPLE_PERIOD  = 3'd3,
    REG_INVERSE_PERIOD = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   integ_gain;
    logic [GAIN_W-1:0]   deriv_gain;
    logic [PERIOD_W-1:0] sample_period;
    logic [PERIOD_W-1:0] inverse_period;
  } hpid_cfg_t;

endpackage

### sv/hpid_if.sv
interface hpid_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_angle;
  logic signed [23:0] measured_angle;

  modport source (output valid, target_angle, measured_angle, input ready);
  modport sink (input valid, target_angle, measured_angle, output ready);
endinterface

interface hpid_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] turn_drive;
  logic               done_res;

  modport source (output valid, turn_drive, done_res, input ready);
  modport sink (input valid, turn_drive, done_res, output ready);
endinterface

### sv/heading_pid_controller.sv
// Fixed-point PID heading loop. Each transfer on sample_in carries a target
// heading (whole degrees) and a gyro heading (Q16.8); one transfer on
// drive_out follows with a saturated Q16.16 turn drive, or a done flag and zero
// drive when the error is exactly zero (integral and previous error cleared).
// All products go through one 26x24 multiplier with a registered output, issued
// seven times in a row by the sequencer (once for a zero error). sample_in is
// ready only in idle, so the next item is taken only after the last result has
// been placed in the output register. A finished result may wait there while
// the next item is taken; the sequencer stalls only if a second result is ready
// before the first has been taken. Gains and periods are to be written on the
// cfg port only while the loop is idle; the block itself does not enforce this.
module heading_pid_controller import hpid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  hpid_in_if.sink               sample_in,
  hpid_out_if.source            drive_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_INT, ST_DRV, ST_PROP, ST_IHI, ST_ILO, ST_DHI, ST_DLO, ST_FIN, ST_OUT
  } state_t;

  state_t state;

  hpid_cfg_t cfg;

  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   last_err;
  logic signed [INTEG_W-1:0] integral;
  logic signed [DERIV_W-1:0] deriv;
  logic signed [SUM_W-1:0]   sum;
  logic                      zero_err;

  logic signed [MUL_A_W-1:0] mul_a;
  logic        [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [SUM_W-1:0]   prod_x;
  logic signed [INTEG_W:0]   int_sum;
  logic signed [INTEG_W-1:0] int_next;
  logic [DRIVE_W-1:0]        drive_sat;
  logic                      out_free;

  hpid_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hpid_mult u_mult (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // operand select for the product issued in each step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_INT: begin
        mul_a = MUL_A_W'(err);
        mul_b = MUL_B_W'(cfg.sample_period);
      end
      ST_DRV: begin
        mul_a = MUL_A_W'(err) - MUL_A_W'(last_err);
        mul_b = MUL_B_W'(cfg.inverse_period);
      end
      ST_PROP: begin
        mul_a = MUL_A_W'(err);
        mul_b = cfg.prop_gain;
      end
      ST_IHI: begin
        mul_a = MUL_A_W'($signed(integral[INTEG_W-1:24]));
        mul_b = cfg.integ_gain;
      end
      ST_ILO: begin
        mul_a = {2'b00, integral[23:0]};
        mul_b = cfg.integ_gain;
      end
      ST_DHI: begin
        mul_a = MUL_A_W'($signed(deriv[DERIV_W-1:24]));
        mul_b = cfg.deriv_gain;
      end
      ST_DLO: begin
        mul_a = {2'b00, deriv[23:0]};
        mul_b = cfg.deriv_gain;
      end
      default: ;
    endcase
  end

  assign prod_x = SUM_W'(prod);

  // integral update with saturation to 48 bits
  assign int_sum = (INTEG_W+1)'(integral) + (INTEG_W+1)'(prod);
  always_comb begin
    if (int_sum[INTEG_W] == int_sum[INTEG_W-1]) begin
      int_next = int_sum[INTEG_W-1:0];
    end else if (int_sum[INTEG_W]) begin
      int_next = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      int_next = {1'b0, {(INTEG_W-1){1'b1}}};
    end
  end

  always_comb begin
    if (&sum[SUM_W-1:DRIVE_W-1] || ~|sum[SUM_W-1:DRIVE_W-1]) begin
      drive_sat = sum[DRIVE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
    end
  end

  assign out_free = !drive_out.valid || drive_out.ready;
  assign sample_in.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      integral        <= '0;
      last_err        <= '0;
      drive_out.valid <= 1'b0;
    end else begin
      // in ST_OUT a taken result is replaced by the next one below
      if (drive_out.valid && drive_out.ready && state != ST_OUT) begin
        drive_out.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample_in.valid) begin
            err <= {sample_in.target_angle[15], sample_in.target_angle, 8'h00}
                   - {sample_in.measured_angle[23], sample_in.measured_angle};
            state <= ST_INT;
          end
        end
        ST_INT: begin
          zero_err <= (err == '0);
          if (err == '0) begin
            integral <= '0;
            last_err <= '0;
            sum      <= '0;
            state    <= ST_OUT;
          end else begin
            state <= ST_DRV;
          end
        end
        ST_DRV: begin
          integral <= int_next;
          state    <= ST_PROP;
        end
        ST_PROP: begin
          deriv    <= prod[DERIV_W-1:0];
          last_err <= err;
          state    <= ST_IHI;
        end
        ST_IHI: begin
          sum   <= prod_x >>> 8;  // proportional term, floor
          state <= ST_ILO;
        end
        ST_ILO: begin
          sum   <= sum + prod_x;  // gain * integral high part
          state <= ST_DHI;
        end
        ST_DHI: begin
          sum   <= sum + (prod_x >>> 24);  // low part is unsigned
          state <= ST_DLO;
        end
        ST_DLO: begin
          sum   <= sum + (prod_x <<< 16);
          state <= ST_FIN;
        end
        ST_FIN: begin
          sum   <= sum + (prod_x >>> 8);
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            drive_out.valid      <= 1'b1;
            drive_out.turn_drive <= drive_sat;
            drive_out.done_res   <= zero_err;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### sv/hpid_cfg.sv
module hpid_cfg import hpid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output hpid_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= '0;
      cfg.integ_gain     <= '0;
      cfg.deriv_gain     <= '0;
      cfg.sample_period  <= SAMPLE_PERIOD_RST;
      cfg.inverse_period <= INVERSE_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:      cfg.prop_gain      <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:     cfg.integ_gain     <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:     cfg.deriv_gain     <= cfg_data[GAIN_W-1:0];
        REG_SAMPLE_PERIOD:  cfg.sample_period  <= cfg_data[PERIOD_W-1:0];
        REG_INVERSE_PERIOD: cfg.inverse_period <= cfg_data[PERIOD_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

### sv/hpid_mult.sv
module hpid_mult import hpid_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic        [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] prod
);

  logic signed [MUL_B_W:0] b_s;

  assign b_s = $signed({1'b0, b});

  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(a * b_s);
  end

endmodule
